### sv/bdpc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package bdpc_pkg;

    // Width of every configuration register and of the write data bus.
    localparam int unsigned CFG_WIDTH = 16;

    // Configuration register indexes.
    typedef enum logic [1:0] {
        CFG_DEBOUNCE_TICKS   = 2'd0,
        CFG_SHORT_MAX_TICKS  = 2'd1,
        CFG_LONG_PRESS_TICKS = 2'd2,
        CFG_REPEAT_TICKS     = 2'd3
    } cfg_index_t;

    // Register values after reset.
    localparam logic [CFG_WIDTH-1:0] DEBOUNCE_TICKS_RST   = 16'd15;
    localparam logic [CFG_WIDTH-1:0] SHORT_MAX_TICKS_RST  = 16'd1000;
    localparam logic [CFG_WIDTH-1:0] LONG_PRESS_TICKS_RST = 16'd2000;
    localparam logic [CFG_WIDTH-1:0] REPEAT_TICKS_RST     = 16'd400;

    // One result, packed so that stable_level lands in bit 0.
    typedef struct packed {
        logic repeat_event;
        logic long_event;
        logic short_event;
        logic press_event;
        logic stable_level;
    } result_t;

    localparam int unsigned RESULT_WIDTH = $bits(result_t);
    localparam int unsigned M_DATA_WIDTH = 8;
    localparam int unsigned S_DATA_WIDTH = 8;

endpackage

`default_nettype wire

### sv/button_debounce_press_classifier_core.sv
`timescale 1ns / 1ps
`default_nettype none

// Button debouncer and press classifier. Each input transaction is one
// millisecond tick that carries the raw, active-low button level in s_tdata
// bit 0. The block debounces the level (the raw level must stay unchanged for
// debounce_ticks ticks before it is taken as stable) and produces exactly one
// output transaction per input transaction: the debounced level plus press,
// short-press, long-press and auto-repeat event flags for that tick. The
// block takes one transaction per clock cycle while the skid entry is empty:
// all per-tick work is a single layer of counter increments and compares
// between the state registers and the output register or skid register.
// A two-entry output stage (output register plus skid register) lets an input
// transaction be taken while a finished result still waits on m_tready; input
// stalls only once both entries are full. Configuration registers are written
// through cfg_we/cfg_addr/cfg_wdata and must only be changed while the block
// is idle. Tick counters are COUNT_WIDTH bits wide and saturate; a
// long-press or repeat time above the counter maximum makes that event
// never fire, and a short-press maximum above it marks every release short.
module button_debounce_press_classifier_core #(
    parameter int unsigned COUNT_WIDTH = 16
) (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    // Configuration write port.
    input  wire logic                                  cfg_we,
    input  wire bdpc_pkg::cfg_index_t                  cfg_addr,
    input  wire logic [bdpc_pkg::CFG_WIDTH-1:0]        cfg_wdata,
    // Input stream. s_tdata: bit 0 pin_level, bits 7:1 zero.
    input  wire logic                                  s_tvalid,
    output logic                                       s_tready,
    input  wire logic [bdpc_pkg::S_DATA_WIDTH-1:0]     s_tdata,
    // Output stream. m_tdata: bit 0 stable_level, bit 1 press_event,
    // bit 2 short_event, bit 3 long_event, bit 4 repeat_event, bits 7:5 zero.
    output logic                                       m_tvalid,
    input  wire logic                                  m_tready,
    output logic [bdpc_pkg::M_DATA_WIDTH-1:0]          m_tdata
);

    import bdpc_pkg::*;

    // Compare width holds both a counter and a register with a spare bit,
    // so both extensions below always have a positive width.
    localparam int unsigned CMP_WIDTH =
        ((COUNT_WIDTH > CFG_WIDTH) ? COUNT_WIDTH : CFG_WIDTH) + 1;
    localparam logic [COUNT_WIDTH-1:0] CNT_MAX = '1;

    // Configuration registers.
    logic [CFG_WIDTH-1:0] debounce_ticks_reg;
    logic [CFG_WIDTH-1:0] short_max_ticks_reg;
    logic [CFG_WIDTH-1:0] long_press_ticks_reg;
    logic [CFG_WIDTH-1:0] repeat_ticks_reg;

    // Per-tick state.
    logic                   sampled_level_reg, sampled_level_next;
    logic                   stable_level_reg, stable_level_next;
    logic                   settling_reg, settling_next;
    logic [COUNT_WIDTH-1:0] settle_count_reg, settle_count_next;
    logic [COUNT_WIDTH-1:0] hold_count_reg, hold_count_next;
    logic [COUNT_WIDTH-1:0] repeat_count_reg, repeat_count_next;
    logic                   long_armed_reg, long_armed_next;
    logic                   repeat_armed_reg, repeat_armed_next;

    // Output stage.
    logic    out_valid_reg, out_valid_next;
    result_t out_data_reg, out_data_next;
    logic    skid_valid_reg, skid_valid_next;
    result_t skid_data_reg, skid_data_next;

    logic    in_accept;
    logic    out_free;
    logic    pin_level;
    result_t result;

    logic [COUNT_WIDTH-1:0] hold_inc;
    logic [COUNT_WIDTH-1:0] repeat_inc;

    // Widen a counter or a register for comparison.
    function automatic logic [CMP_WIDTH-1:0] cnt_ext(input logic [COUNT_WIDTH-1:0] v);
        cnt_ext = {{(CMP_WIDTH - COUNT_WIDTH){1'b0}}, v};
    endfunction

    function automatic logic [CMP_WIDTH-1:0] cfg_ext(input logic [CFG_WIDTH-1:0] v);
        cfg_ext = {{(CMP_WIDTH - CFG_WIDTH){1'b0}}, v};
    endfunction

    assign pin_level = s_tdata[0];
    assign s_tready  = ~skid_valid_reg;
    assign in_accept = s_tvalid & s_tready;
    assign out_free  = ~out_valid_reg | m_tready;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(M_DATA_WIDTH - RESULT_WIDTH){1'b0}}, out_data_reg};

    // Configuration writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            debounce_ticks_reg   <= DEBOUNCE_TICKS_RST;
            short_max_ticks_reg  <= SHORT_MAX_TICKS_RST;
            long_press_ticks_reg <= LONG_PRESS_TICKS_RST;
            repeat_ticks_reg     <= REPEAT_TICKS_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                CFG_DEBOUNCE_TICKS:   debounce_ticks_reg   <= cfg_wdata;
                CFG_SHORT_MAX_TICKS:  short_max_ticks_reg  <= cfg_wdata;
                CFG_LONG_PRESS_TICKS: long_press_ticks_reg <= cfg_wdata;
                CFG_REPEAT_TICKS:     repeat_ticks_reg     <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // One tick of debounce and classification.
    always_comb
    begin
        hold_inc   = (hold_count_reg == CNT_MAX) ? CNT_MAX : hold_count_reg + 1'b1;
        repeat_inc = (repeat_count_reg == CNT_MAX) ? CNT_MAX : repeat_count_reg + 1'b1;

        sampled_level_next = sampled_level_reg;
        stable_level_next  = stable_level_reg;
        settling_next      = settling_reg;
        settle_count_next  = settle_count_reg;
        hold_count_next    = hold_inc;
        repeat_count_next  = repeat_inc;
        long_armed_next    = long_armed_reg;
        repeat_armed_next  = repeat_armed_reg;
        result             = '0;

        // Any raw change restarts the settle count.
        if (pin_level != sampled_level_reg)
        begin
            sampled_level_next = pin_level;
            settling_next      = 1'b1;
            settle_count_next  = '0;
        end
        else if (settling_reg)
        begin
            settle_count_next = (settle_count_reg == CNT_MAX) ? CNT_MAX
                                                              : settle_count_reg + 1'b1;
        end

        if (settling_next &&
            (cnt_ext(settle_count_next) >= cfg_ext(debounce_ticks_reg)))
        begin
            stable_level_next = sampled_level_next;
            settling_next     = 1'b0;
        end

        // The previous debounced level is always the registered one, so an
        // edge is simply a change of the debounced level in this tick.
        if (stable_level_next != stable_level_reg)
        begin
            if (!stable_level_next)
            begin
                result.press_event = 1'b1;
                long_armed_next    = 1'b1;
                repeat_armed_next  = 1'b1;
                hold_count_next    = '0;
                repeat_count_next  = '0;
            end
            else
            begin
                result.short_event =
                    (cnt_ext(hold_inc) <= cfg_ext(short_max_ticks_reg));
                long_armed_next    = 1'b0;
                repeat_armed_next  = 1'b0;
            end
        end

        if (long_armed_next &&
            (cnt_ext(hold_count_next) >= cfg_ext(long_press_ticks_reg)))
        begin
            result.long_event = 1'b1;
            long_armed_next   = 1'b0;
        end

        if (repeat_armed_next &&
            (cnt_ext(repeat_count_next) >= cfg_ext(repeat_ticks_reg)))
        begin
            result.repeat_event = 1'b1;
            repeat_count_next   = '0;
        end

        result.stable_level = stable_level_next;
    end

    // State advances only on an accepted tick.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sampled_level_reg <= 1'b1;
            stable_level_reg  <= 1'b1;
            settling_reg      <= 1'b0;
            settle_count_reg  <= '0;
            hold_count_reg    <= '0;
            repeat_count_reg  <= '0;
            long_armed_reg    <= 1'b0;
            repeat_armed_reg  <= 1'b0;
        end
        else if (in_accept)
        begin
            sampled_level_reg <= sampled_level_next;
            stable_level_reg  <= stable_level_next;
            settling_reg      <= settling_next;
            settle_count_reg  <= settle_count_next;
            hold_count_reg    <= hold_count_next;
            repeat_count_reg  <= repeat_count_next;
            long_armed_reg    <= long_armed_next;
            repeat_armed_reg  <= repeat_armed_next;
        end
    end

    // Output register with skid entry. The skid entry fills only when a
    // result arrives while the output register is held by the sink.
    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;
        skid_valid_next = skid_valid_reg;
        skid_data_next  = skid_data_reg;

        if (out_free)
        begin
            if (skid_valid_reg)
            begin
                out_valid_next  = 1'b1;
                out_data_next   = skid_data_reg;
                skid_valid_next = 1'b0;
            end
            else
            begin
                out_valid_next = in_accept;
                out_data_next  = result;
            end
        end
        else if (in_accept)
        begin
            skid_valid_next = 1'b1;
            skid_data_next  = result;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

endmodule

`default_nettype wire
